[hdl/ubx_tfs_pkg.sv]
`default_nettype none

package ubx_tfs_pkg;

	// Frame constants
	localparam logic [7:0] SYNC_A    = 8'hB5;
	localparam logic [7:0] SYNC_B    = 8'h62;
	localparam logic [7:0] TIM_CLASS = 8'h0D;
	localparam logic [7:0] TP_ID     = 8'h01;
	localparam int unsigned MODE_BIT_POS = 3;

	// Payload offsets of the captured fields
	localparam logic [15:0] OFS_QERR0 = 16'd8;
	localparam logic [15:0] OFS_QERR1 = 16'd9;
	localparam logic [15:0] OFS_QERR2 = 16'd10;
	localparam logic [15:0] OFS_QERR3 = 16'd11;
	localparam logic [15:0] OFS_FLAGS = 16'd14;

	// Default expected payload length of a timing frame
	localparam int unsigned PAYLOAD_BYTES_DEF = 16;

	typedef struct packed {
		logic [7:0]  byte_in;
		logic [31:0] pps_count;
	} item_t;

	typedef struct packed {
		logic               qerr_ready;
		logic signed [31:0] qerr_ps;
		logic [7:0]         pulse_flags;
		logic               next_pulse_mode;
		logic [31:0]        pps_tag;
		logic [31:0]        frame_count;
	} result_t;

endpackage

`default_nettype wire

[hdl/ubx_tfs_parser.sv]
`default_nettype none

module ubx_tfs_parser #(
	parameter int unsigned PAYLOAD_BYTES = ubx_tfs_pkg::PAYLOAD_BYTES_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   step,
	input  ubx_tfs_pkg::item_t    item,
	output ubx_tfs_pkg::result_t  res
);

	typedef enum logic [3:0] {
		PH_SYNC1   = 4'd0,
		PH_SYNC2   = 4'd1,
		PH_CLASS   = 4'd2,
		PH_ID      = 4'd3,
		PH_LEN1    = 4'd4,
		PH_LEN2    = 4'd5,
		PH_PAYLOAD = 4'd6,
		PH_CKA     = 4'd7,
		PH_CKB     = 4'd8
	} phase_t;

	localparam logic [15:0] TIM_LEN = 16'(PAYLOAD_BYTES);

	phase_t      phase_q, phase_d;
	logic [7:0]  class_q;
	logic [7:0]  id_q;
	logic [15:0] len_q;
	logic [15:0] idx_q;
	logic [7:0]  sum_a_q, sum_b_q;
	logic [7:0]  rx_sum_a_q;
	logic [31:0] frames_q;
	logic [7:0]  qerr_b0_q, qerr_b1_q, qerr_b2_q, qerr_b3_q, flags_q;

	logic [7:0]  b;
	logic [7:0]  base_a, base_b, nxt_a, nxt_b;
	logic [15:0] idx_inc;
	logic [15:0] len_full;
	logic        is_timing;
	logic        good;

	assign b         = item.byte_in;
	assign is_timing = (class_q == ubx_tfs_pkg::TIM_CLASS) && (id_q == ubx_tfs_pkg::TP_ID)
		&& (len_q == TIM_LEN);
	assign idx_inc   = idx_q + 16'd1;
	assign len_full  = {b, len_q[7:0]};

	// Fletcher update; the class byte restarts both sums
	assign base_a = (phase_q == PH_CLASS) ? 8'd0 : sum_a_q;
	assign base_b = (phase_q == PH_CLASS) ? 8'd0 : sum_b_q;
	assign nxt_a  = base_a + b;
	assign nxt_b  = base_b + nxt_a;

	assign good = (phase_q == PH_CKB) && (rx_sum_a_q == sum_a_q) && (b == sum_b_q)
		&& is_timing;

	// Next phase
	always_comb begin
		case (phase_q)
			PH_SYNC1:   phase_d = (b == ubx_tfs_pkg::SYNC_A) ? PH_SYNC2 : PH_SYNC1;
			PH_SYNC2:   phase_d = (b == ubx_tfs_pkg::SYNC_B) ? PH_CLASS : PH_SYNC1;
			PH_CLASS:   phase_d = PH_ID;
			PH_ID:      phase_d = PH_LEN1;
			PH_LEN1:    phase_d = PH_LEN2;
			PH_LEN2:    phase_d = (len_full == 16'd0) ? PH_CKA : PH_PAYLOAD;
			PH_PAYLOAD: phase_d = (idx_inc >= len_q) ? PH_CKA : PH_PAYLOAD;
			PH_CKA:     phase_d = PH_CKB;
			default:    phase_d = PH_SYNC1;
		endcase
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SYNC1;
			class_q    <= '0;
			id_q       <= '0;
			len_q      <= '0;
			idx_q      <= '0;
			sum_a_q    <= '0;
			sum_b_q    <= '0;
			rx_sum_a_q <= '0;
			frames_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			case (phase_q)
				PH_CLASS: begin
					class_q <= b;
					sum_a_q <= nxt_a;
					sum_b_q <= nxt_b;
				end
				PH_ID: begin
					id_q    <= b;
					sum_a_q <= nxt_a;
					sum_b_q <= nxt_b;
				end
				PH_LEN1: begin
					len_q   <= {8'd0, b};
					sum_a_q <= nxt_a;
					sum_b_q <= nxt_b;
				end
				PH_LEN2: begin
					len_q   <= len_full;
					idx_q   <= '0;
					sum_a_q <= nxt_a;
					sum_b_q <= nxt_b;
				end
				PH_PAYLOAD: begin
					idx_q   <= idx_inc;
					sum_a_q <= nxt_a;
					sum_b_q <= nxt_b;
				end
				PH_CKA: begin
					rx_sum_a_q <= b;
				end
				PH_CKB: begin
					if (good) begin
						frames_q <= frames_q + 32'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Capture of the payload bytes that feed the result
	always_ff @(posedge clk) begin
		if (step && (phase_q == PH_PAYLOAD) && is_timing) begin
			if (idx_q == ubx_tfs_pkg::OFS_QERR0) qerr_b0_q <= b;
			if (idx_q == ubx_tfs_pkg::OFS_QERR1) qerr_b1_q <= b;
			if (idx_q == ubx_tfs_pkg::OFS_QERR2) qerr_b2_q <= b;
			if (idx_q == ubx_tfs_pkg::OFS_QERR3) qerr_b3_q <= b;
			if (idx_q == ubx_tfs_pkg::OFS_FLAGS) flags_q   <= b;
		end
	end

	// Result of the current byte; all zero unless a frame was accepted
	always_comb begin
		res = '0;
		if (good) begin
			res.qerr_ready      = 1'b1;
			res.qerr_ps         = {qerr_b3_q, qerr_b2_q, qerr_b1_q, qerr_b0_q};
			res.pulse_flags     = flags_q;
			res.next_pulse_mode = flags_q[ubx_tfs_pkg::MODE_BIT_POS];
			res.pps_tag         = item.pps_count;
			res.frame_count     = frames_q + 32'd1;
		end
	end

`ifndef SYNTHESIS
	// Frame counter moves only on an accepted frame, by one
	assert property (@(posedge clk) disable iff (!arst_n)
		step && good |=> frames_q == $past(frames_q) + 32'd1)
		else $error("frame count not advanced on good frame");
	assert property (@(posedge clk) disable iff (!arst_n)
		!(step && good) |=> $stable(frames_q))
		else $error("frame count moved without good frame");
	// A frame is reported only on the second checksum byte
	assert property (@(posedge clk) disable iff (!arst_n)
		res.qerr_ready |-> phase_q == PH_CKB)
		else $error("frame reported outside the checksum phase");
`endif

endmodule

`default_nettype wire

[hdl/ubx_timing_frame_sniffer.sv]
// An accepted transaction is held in the input register and steps the parser into the result
// register when the output is free. The parser state updates once per byte in a single pass.
// Throughput: one byte per cycle unless result_stall holds a result in the result register.
// Reset (arst_n low) clears the parser state, the frame counter and both valid flags;
// the captured payload bytes and data registers are not reset.
`default_nettype none

module ubx_timing_frame_sniffer #(
	parameter int unsigned PAYLOAD_BYTES = ubx_tfs_pkg::PAYLOAD_BYTES_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   item_valid,
	output logic                  item_stall,
	input  ubx_tfs_pkg::item_t    item,
	output logic                  result_valid,
	input  wire                   result_stall,
	output ubx_tfs_pkg::result_t  result
);

	logic                  valid_s1;
	ubx_tfs_pkg::item_t    item_s1;
	ubx_tfs_pkg::result_t  res_d;
	logic                  out_free;
	logic                  advance;
	logic                  take;

	assign out_free   = !result_valid || !result_stall;
	assign advance    = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;
	assign take       = item_valid && !item_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item;
		end
	end

	ubx_tfs_parser #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.res    (res_d)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result <= res_d;
		end
	end

`ifndef SYNTHESIS
	// Stall only while a transaction waits in the input register
	assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1)
		else $error("input stalled with empty input register");
	// Every processed byte yields a result
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result_valid)
		else $error("processed byte produced no result");
	// Mode bit follows the flags byte
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.next_pulse_mode
			== result.pulse_flags[ubx_tfs_pkg::MODE_BIT_POS])
		else $error("mode bit does not match flags");
	// No frame means empty fields
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.qerr_ready |-> result.frame_count == 32'd0
			&& result.pps_tag == 32'd0)
		else $error("fields set without an accepted frame");
`endif

endmodule

`default_nettype wire

[tb/ubx_tfs_checker.sv]
`timescale 1ns / 1ps

module ubx_tfs_checker
	import ubx_tfs_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         item_valid,
	input  wire         item_stall,
	input  item_t       item,
	input  wire         result_valid,
	input  wire         result_stall,
	input  result_t     result,
	output int unsigned fail_count,
	output int unsigned pending
);

	localparam int unsigned IDX_W = $clog2(PAYLOAD_BYTES_DEF);

	typedef enum logic [3:0] {
		ST_HUNT1,
		ST_HUNT2,
		ST_CLASS,
		ST_ID,
		ST_LEN_LO,
		ST_LEN_HI,
		ST_BODY,
		ST_CK_A,
		ST_CK_B
	} parse_st_t;

	// Shadow copy of the parser
	parse_st_t   phase;
	logic [7:0]  msg_cls;
	logic [7:0]  msg_ident;
	logic [15:0] body_len;
	logic [15:0] body_idx;
	logic [7:0]  ck_a;
	logic [7:0]  ck_b;
	logic [7:0]  rx_ck_a;
	logic [7:0]  body_mem [PAYLOAD_BYTES_DEF];
	logic [31:0] frames_seen;

	result_t     frame_report_q [$];
	result_t     predicted;
	result_t     oldest;

	task automatic fold_sum(input logic [7:0] b);
		ck_a = ck_a + b;
		ck_b = ck_b + ck_a;
	endtask

	// Advance the parser by one byte and work out the result it gives
	task automatic parse_byte(input logic [7:0] b, input logic [31:0] pps, output result_t r);
		logic       tp;
		logic [7:0] fl;
		tp = (msg_cls == TIM_CLASS) && (msg_ident == TP_ID) &&
			(body_len == 16'(PAYLOAD_BYTES_DEF));
		r = '0;
		case (phase)
			ST_HUNT1: begin
				if (b == SYNC_A)
					phase = ST_HUNT2;
			end
			ST_HUNT2: begin
				// a wrong second sync byte is not retried as a first one
				phase = (b == SYNC_B) ? ST_CLASS : ST_HUNT1;
			end
			ST_CLASS: begin
				msg_cls = b;
				ck_a = 8'h00;
				ck_b = 8'h00;
				fold_sum(b);
				phase = ST_ID;
			end
			ST_ID: begin
				msg_ident = b;
				fold_sum(b);
				phase = ST_LEN_LO;
			end
			ST_LEN_LO: begin
				body_len = {8'h00, b};
				fold_sum(b);
				phase = ST_LEN_HI;
			end
			ST_LEN_HI: begin
				body_len[15:8] = b;
				fold_sum(b);
				body_idx = 16'd0;
				phase = (body_len == 16'd0) ? ST_CK_A : ST_BODY;
			end
			ST_BODY: begin
				fold_sum(b);
				if (tp && body_idx < 16'(PAYLOAD_BYTES_DEF))
					body_mem[body_idx[IDX_W-1:0]] = b;
				body_idx = body_idx + 16'd1;
				if (body_idx >= body_len)
					phase = ST_CK_A;
			end
			ST_CK_A: begin
				rx_ck_a = b;
				phase = ST_CK_B;
			end
			ST_CK_B: begin
				if (rx_ck_a == ck_a && b == ck_b && tp) begin
					fl = body_mem[OFS_FLAGS[IDX_W-1:0]];
					frames_seen = frames_seen + 32'd1;
					r.qerr_ready      = 1'b1;
					r.qerr_ps         = {body_mem[OFS_QERR3[IDX_W-1:0]],
						body_mem[OFS_QERR2[IDX_W-1:0]],
						body_mem[OFS_QERR1[IDX_W-1:0]],
						body_mem[OFS_QERR0[IDX_W-1:0]]};
					r.pulse_flags     = fl;
					r.next_pulse_mode = fl[MODE_BIT_POS];
					r.pps_tag         = pps;
					r.frame_count     = frames_seen;
				end
				phase = ST_HUNT1;
			end
			default: phase = ST_HUNT1;
		endcase
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		if (fail_count < 40)
			$display("%0t: %s: got %h, expected %h", $time, what, got, want);
		fail_count++;
	endtask

	// Watch both channels: predict on each input transaction, compare on each result
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase = ST_HUNT1;
			msg_cls = 8'h00;
			msg_ident = 8'h00;
			body_len = 16'd0;
			body_idx = 16'd0;
			ck_a = 8'h00;
			ck_b = 8'h00;
			rx_ck_a = 8'h00;
			frames_seen = 32'd0;
			frame_report_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (frame_report_q.size() == 0) begin
					report_mismatch("result with nothing expected, frame_count",
						result.frame_count, 32'h0);
				end else begin
					oldest = frame_report_q.pop_front();
					if (result.qerr_ready !== oldest.qerr_ready)
						report_mismatch("qerr_ready", 32'(result.qerr_ready),
							32'(oldest.qerr_ready));
					if (result.qerr_ps !== oldest.qerr_ps)
						report_mismatch("qerr_ps", result.qerr_ps, oldest.qerr_ps);
					if (result.pulse_flags !== oldest.pulse_flags)
						report_mismatch("pulse_flags", 32'(result.pulse_flags),
							32'(oldest.pulse_flags));
					if (result.next_pulse_mode !== oldest.next_pulse_mode)
						report_mismatch("next_pulse_mode", 32'(result.next_pulse_mode),
							32'(oldest.next_pulse_mode));
					if (result.pps_tag !== oldest.pps_tag)
						report_mismatch("pps_tag", result.pps_tag, oldest.pps_tag);
					if (result.frame_count !== oldest.frame_count)
						report_mismatch("frame_count", result.frame_count, oldest.frame_count);
				end
			end
			if (item_valid && !item_stall) begin
				parse_byte(item.byte_in, item.pps_count, predicted);
				frame_report_q.push_back(predicted);
			end
			pending = frame_report_q.size();
		end
	end

endmodule

[tb/tb_ubx_timing_frame_sniffer.sv]
`timescale 1ns / 1ps

module tb_ubx_timing_frame_sniffer;
	import ubx_tfs_pkg::*;

	localparam int unsigned N_BYTES     = 1000;
	localparam int unsigned QUIET_TAIL  = 150;
	localparam int unsigned CYCLE_LIMIT = 200000;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	item_t       item;
	logic        result_valid;
	logic        result_stall;
	result_t     result;

	int unsigned fail_count;
	int unsigned pending;
	int unsigned n_sent;
	int unsigned cycles;
	bit          idle_en;
	logic [7:0]  body_q [$];

	ubx_timing_frame_sniffer u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	ubx_tfs_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Result side back-pressure in short random bursts
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left != 0) begin
				result_stall <= 1'b1;
				stall_left--;
			end else if (idle_en && $urandom_range(4) == 0) begin
				result_stall <= 1'b1;
				stall_left = $urandom_range(0, 2);
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// One byte transaction; called and returns at a falling edge
	task automatic send_byte(input logic [7:0] b, input logic [31:0] pps);
		if (idle_en && $urandom_range(4) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		item_valid <= 1'b1;
		item <= '{byte_in: b, pps_count: pps};
		do
			@(posedge clk);
		while (item_stall);
		n_sent++;
		@(negedge clk);
	endtask

	task automatic fill_body(input int unsigned n);
		body_q.delete();
		repeat (n) body_q.push_back(8'($urandom));
	endtask

	// Sync, header, body_q and checksum; bad_ck 1 or 2 corrupts the first or second sum byte
	task automatic emit_frame(input logic [7:0] cls, input logic [7:0] ident,
		input logic [15:0] len, input int unsigned bad_ck);
		logic [7:0] a;
		logic [7:0] s;
		logic [7:0] hdr [4];
		a = 8'h00;
		s = 8'h00;
		hdr = '{cls, ident, len[7:0], len[15:8]};
		send_byte(SYNC_A, $urandom);
		send_byte(SYNC_B, $urandom);
		foreach (hdr[i]) begin
			a = a + hdr[i];
			s = s + a;
			send_byte(hdr[i], $urandom);
		end
		foreach (body_q[i]) begin
			a = a + body_q[i];
			s = s + a;
			send_byte(body_q[i], $urandom);
		end
		if (bad_ck == 1)
			a = a ^ 8'($urandom_range(1, 255));
		if (bad_ck == 2)
			s = s ^ 8'($urandom_range(1, 255));
		send_byte(a, $urandom);
		send_byte(s, $urandom);
	endtask

	initial begin
		int unsigned pick;
		int unsigned n;
		logic [7:0]  cls;
		logic [7:0]  ident;
		logic [15:0] len;

		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		idle_en = 1'b1;
		n_sent = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: field extremes on noise bytes
		send_byte(8'h00, 32'h0000_0000);
		send_byte(8'hFF, 32'hFFFF_FFFF);
		// wrong second sync byte, then a stray second sync byte
		send_byte(SYNC_A, $urandom);
		send_byte(SYNC_A, $urandom);
		send_byte(SYNC_B, $urandom);
		// zero length timing class frame
		body_q.delete();
		emit_frame(TIM_CLASS, TP_ID, 16'd0, 0);
		// good timing frame, most negative error, next-pulse flag set
		fill_body(PAYLOAD_BYTES_DEF);
		body_q[8] = 8'h00;
		body_q[9] = 8'h00;
		body_q[10] = 8'h00;
		body_q[11] = 8'h80;
		body_q[14] = 8'h08;
		emit_frame(TIM_CLASS, TP_ID, 16'(PAYLOAD_BYTES_DEF), 0);

		// Random stream: mostly well-formed frames, some near misses and noise
		while (n_sent < N_BYTES) begin
			idle_en = (n_sent < N_BYTES - QUIET_TAIL) && ((n_sent / 120) % 4 != 3);
			pick = $urandom_range(99);
			if (pick < 50) begin
				fill_body(PAYLOAD_BYTES_DEF);
				emit_frame(TIM_CLASS, TP_ID, 16'(PAYLOAD_BYTES_DEF),
					(pick < 8) ? 1 + pick % 2 : 0);
			end else if (pick < 62) begin
				// one of class, id or length off by a little
				cls = TIM_CLASS;
				ident = TP_ID;
				len = 16'(PAYLOAD_BYTES_DEF);
				case ($urandom_range(2))
					0: cls = cls ^ 8'($urandom_range(1, 255));
					1: ident = ident ^ 8'($urandom_range(1, 255));
					default: len = ($urandom_range(1)) ? len - 16'd1 : len + 16'd1;
				endcase
				fill_body(len);
				emit_frame(cls, ident, len, 0);
			end else if (pick < 72) begin
				// unrelated frame, now and then a long one
				len = 16'($urandom_range(24));
				if ($urandom_range(15) == 0)
					len = 16'($urandom_range(256, 511));
				fill_body(len);
				emit_frame(8'($urandom), 8'($urandom), len, $urandom_range(2));
			end else if (pick < 78) begin
				body_q.delete();
				emit_frame(($urandom_range(1)) ? TIM_CLASS : 8'($urandom), TP_ID, 16'd0,
					$urandom_range(2));
			end else if (pick < 86) begin
				// truncated timing frame; the next bytes get absorbed into it
				send_byte(SYNC_A, $urandom);
				send_byte(SYNC_B, $urandom);
				send_byte(TIM_CLASS, $urandom);
				send_byte(TP_ID, $urandom);
				send_byte(8'(PAYLOAD_BYTES_DEF), $urandom);
				send_byte(8'h00, $urandom);
				repeat ($urandom_range(0, PAYLOAD_BYTES_DEF - 1))
					send_byte(8'($urandom), $urandom);
			end else begin
				// noise biased towards sync bytes
				n = $urandom_range(1, 6);
				repeat (n) begin
					pick = $urandom_range(9);
					if (pick < 3)
						send_byte(SYNC_A, $urandom);
					else if (pick < 5)
						send_byte(SYNC_B, $urandom);
					else
						send_byte(8'($urandom), $urandom);
				end
			end
		end
		item_valid <= 1'b0;

		// Drain outstanding results, then allow for the result register
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[ubx_timing_frame_sniffer.f]
hdl/ubx_tfs_pkg.sv
hdl/ubx_tfs_parser.sv
hdl/ubx_timing_frame_sniffer.sv
tb/ubx_tfs_checker.sv
tb/tb_ubx_timing_frame_sniffer.sv
